// File: rtl/sgr_mouse_report_encoder_top_assert.svh
`ifndef SGR_MOUSE_REPORT_ENCODER_TOP_ASSERT_SVH
`define SGR_MOUSE_REPORT_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sre_pkg.sv
package sre_pkg;

  localparam int CoordBits = 16;
  localparam int FieldW    = 16;
  localparam int NumW      = CoordBits;
  localparam int MulW      = NumW + 4;
  localparam int CodeW     = 7;
  localparam int PlaceW    = 3;
  localparam logic [PlaceW-1:0] TopPlace = 3'd4;

  localparam logic [7:0] ByteEsc   = 8'h1b;
  localparam logic [7:0] ByteLbr   = 8'h5b;
  localparam logic [7:0] ByteLt    = 8'h3c;
  localparam logic [7:0] ByteSemi  = 8'h3b;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] BytePress = 8'h4d;
  localparam logic [7:0] ByteRel   = 8'h6d;

  typedef struct packed {
    logic [NumW-1:0] code;
    logic [NumW-1:0] col;
    logic [NumW-1:0] row;
    logic            release_evt;
  } sre_load_t;

  function automatic logic [MulW-1:0] pow10(input logic [PlaceW-1:0] place);
    logic [MulW-1:0] p;
    case (place)
      3'd0:    p = MulW'(1);
      3'd1:    p = MulW'(10);
      3'd2:    p = MulW'(100);
      3'd3:    p = MulW'(1000);
      default: p = MulW'(10000);
    endcase
    return p;
  endfunction

endpackage

// File: rtl/sre_digit.sv
module sre_digit import sre_pkg::*; (
  input  logic [NumW-1:0]   val_i,
  input  logic [PlaceW-1:0] place_i,
  output logic [3:0]        digit_o,
  output logic [NumW-1:0]   rem_o
);

  always_comb begin
    logic [MulW-1:0] p;
    logic [MulW-1:0] m;
    logic [MulW-1:0] sel;
    logic [MulW-1:0] v;
    v       = {{(MulW-NumW){1'b0}}, val_i};
    p       = pow10(place_i);
    digit_o = '0;
    sel     = '0;
    for (int k = 1; k < 10; k++) begin
      m = MulW'(k) * p;
      if (v >= m) begin
        digit_o = 4'(k);
        sel     = m;
      end
    end
    rem_o = NumW'(v - sel);
  end

endmodule

// File: rtl/sre_seq.sv
module sre_seq import sre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sre_load_t load_i,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [7:0] out_byte_o,
  output logic      last_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEsc  = 3'd1;
  localparam logic [2:0] StLbr  = 3'd2;
  localparam logic [2:0] StLt   = 3'd3;
  localparam logic [2:0] StDig  = 3'd4;
  localparam logic [2:0] StSep  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;

  localparam logic [1:0] FldCode = 2'd0;
  localparam logic [1:0] FldCol  = 2'd1;
  localparam logic [1:0] FldRow  = 2'd2;

  logic [2:0]        state_q, state_d;
  logic [1:0]        fld_q, fld_d;
  logic [PlaceW-1:0] place_q, place_d;
  logic              started_q, started_d;
  logic [NumW-1:0]   val_q, val_d;
  logic [NumW-1:0]   col_q, col_d;
  logic [NumW-1:0]   row_q, row_d;
  logic              rel_q, rel_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              olast_q, olast_d;

  logic [3:0]      digit;
  logic [NumW-1:0] rem;
  logic            adv;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_last;

  sre_digit u_digit (
    .val_i   (val_q),
    .place_i (place_q),
    .digit_o (digit),
    .rem_o   (rem)
  );

  assign adv = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    fld_d     = fld_q;
    place_d   = place_q;
    started_d = started_q;
    val_d     = val_q;
    col_d     = col_q;
    row_d     = row_q;
    rel_d     = rel_q;
    emit      = 1'b0;
    emit_byte = ByteEsc;
    emit_last = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          val_d   = load_i.code;
          col_d   = load_i.col;
          row_d   = load_i.row;
          rel_d   = load_i.release_evt;
          state_d = StEsc;
        end
      end
      StEsc: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = ByteEsc;
          state_d   = StLbr;
        end
      end
      StLbr: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = ByteLbr;
          state_d   = StLt;
        end
      end
      StLt: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = ByteLt;
          fld_d     = FldCode;
          place_d   = TopPlace;
          started_d = 1'b0;
          state_d   = StDig;
        end
      end
      StDig: begin
        if (adv) begin
          emit      = (digit != 4'd0) || started_q || (place_q == '0);
          emit_byte = ByteZero + {4'd0, digit};
          started_d = started_q || emit;
          val_d     = rem;
          place_d   = place_q - PlaceW'(1);
          if (place_q == '0) begin
            state_d = (fld_q == FldRow) ? StFin : StSep;
          end
        end
      end
      StSep: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = ByteSemi;
          fld_d     = fld_q + 2'd1;
          val_d     = (fld_q == FldCode) ? col_q : row_q;
          place_d   = TopPlace;
          started_d = 1'b0;
          state_d   = StDig;
        end
      end
      StFin: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = rel_q ? ByteRel : BytePress;
          emit_last = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (adv) begin
      ovalid_d = emit;
      obyte_d  = emit_byte;
      olast_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fld_q   <= fld_d;
    place_q <= place_d;
    val_q   <= val_d;
    col_q   <= col_d;
    row_q   <= row_d;
    rel_q   <= rel_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

endmodule

// File: rtl/sgr_mouse_report_encoder_top.sv
// channel  | direction | signals
// input    | in        | in_valid_i, in_stall_o, event_kind_i, button_i, modifiers_i,
//          |           | row_i, column_i
// output   | out       | out_valid_o, out_stall_i, out_byte_o, last_o
// config   | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// A reported event runs the sequencer through an accept step, three header beats, five
// digit steps for each of the three numbers on the shared digit unit, two separators and the
// final beat. While out_stall_i holds a waiting beat, the sequencer does not advance.
// An event that gives no report is accepted without starting the sequencer.
// Reset clears both config registers, the sequencer state and the output valid register.
module sgr_mouse_report_encoder_top import sre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        event_kind_i,
  input  logic [2:0]        button_i,
  input  logic [2:0]        modifiers_i,
  input  logic [FieldW-1:0] row_i,
  input  logic [FieldW-1:0] column_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [2:0]        cfg_data_i
);

  localparam logic CfgSgr  = 1'b0;
  localparam logic CfgMode = 1'b1;

  localparam logic [2:0] KindPress   = 3'd0;
  localparam logic [2:0] KindRelease = 3'd1;
  localparam logic [2:0] KindDrag    = 3'd2;
  localparam logic [2:0] KindMove    = 3'd3;
  localparam logic [2:0] KindWheel   = 3'd4;

  localparam logic [2:0] BtnRight   = 3'd2;
  localparam logic [2:0] BtnWheelUp = 3'd4;
  localparam logic [2:0] BtnWheelDn = 3'd5;

  localparam logic [2:0] ModeNone     = 3'd0;
  localparam logic [2:0] ModeX10      = 3'd1;
  localparam logic [2:0] ModeBtnEvent = 3'd3;
  localparam logic [2:0] ModeAnyEvent = 3'd4;

  logic       sgr_q;
  logic [2:0] mode_q;

  logic             busy;
  logic             accept;
  logic             report;
  logic             kind_ok;
  logic             pressable;
  logic             rel;
  logic [CodeW-1:0] base;
  sre_load_t        load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgr_q  <= 1'b0;
      mode_q <= ModeNone;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgSgr:  sgr_q  <= cfg_data_i[0];
        CfgMode: mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pressable = (button_i <= BtnRight);

  always_comb begin
    kind_ok = 1'b0;
    rel     = 1'b0;
    base    = CodeW'(button_i);
    case (event_kind_i)
      KindPress: begin
        kind_ok = pressable;
      end
      KindRelease: begin
        kind_ok = pressable;
        rel     = 1'b1;
      end
      KindDrag: begin
        kind_ok = pressable && (mode_q == ModeBtnEvent || mode_q == ModeAnyEvent);
        base    = CodeW'(button_i) + CodeW'(32);
      end
      KindMove: begin
        kind_ok = (mode_q == ModeAnyEvent);
        base    = CodeW'(35);
      end
      KindWheel: begin
        kind_ok = (button_i == BtnWheelUp || button_i == BtnWheelDn);
        base    = CodeW'(button_i) + CodeW'(60);
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  assign report = sgr_q && (mode_q > ModeX10) && !row_i[CoordBits-1] && !column_i[CoordBits-1]
                  && kind_ok;

  assign load.code        = NumW'(base + {2'b00, modifiers_i, 2'b00});
  assign load.col         = {1'b0, column_i[CoordBits-2:0]} + NumW'(1);
  assign load.row         = {1'b0, row_i[CoordBits-2:0]} + NumW'(1);
  assign load.release_evt = rel;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  sre_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && report),
    .load_i      (load),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/sre_chk.sv
`include "sgr_mouse_report_encoder_top_assert.svh"

module sre_chk import sre_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [7:0]        out_byte_o,
  input logic              last_o
);

  `SRE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(last_o), "stalled beat changed")
  `SRE_ASSERT_NOW(a_idle_after_last, $fell(in_stall_o), out_valid_o && last_o, "sequencer went idle without a final beat")
  `SRE_ASSERT_NOW(a_last_byte, out_valid_o && last_o, out_byte_o == BytePress || out_byte_o == ByteRel, "final beat is not M or m")
  `SRE_ASSERT_NOW(a_esc_not_last, out_valid_o && out_byte_o == ByteEsc, !last_o, "escape beat marked last")

endmodule

bind sgr_mouse_report_encoder_top sre_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o)
);

// File: verif/sgr_mouse_report_encoder_top_tb.sv
`timescale 1ns / 100ps

module sgr_mouse_report_encoder_top_tb import sre_pkg::*;;

  localparam logic       RegSgr = 1'b0;
  localparam logic       RegTrk = 1'b1;

  localparam logic [2:0] TrkNone     = 3'd0;
  localparam logic [2:0] TrkX10      = 3'd1;
  localparam logic [2:0] TrkPressRel = 3'd2;
  localparam logic [2:0] TrkButton   = 3'd3;
  localparam logic [2:0] TrkAny      = 3'd4;
  localparam logic [2:0] TrkUnk5     = 3'd5;
  localparam logic [2:0] TrkUnk6     = 3'd6;
  localparam logic [2:0] TrkUnk7     = 3'd7;

  localparam logic [2:0] KindPress   = 3'd0;
  localparam logic [2:0] KindRelease = 3'd1;
  localparam logic [2:0] KindDrag    = 3'd2;
  localparam logic [2:0] KindMove    = 3'd3;
  localparam logic [2:0] KindWheel   = 3'd4;
  localparam logic [2:0] KindUnk5    = 3'd5;
  localparam logic [2:0] KindUnk7    = 3'd7;

  localparam logic [2:0] BtnLeft      = 3'd0;
  localparam logic [2:0] BtnMiddle    = 3'd1;
  localparam logic [2:0] BtnRight     = 3'd2;
  localparam logic [2:0] BtnNone      = 3'd3;
  localparam logic [2:0] BtnWheelUp   = 3'd4;
  localparam logic [2:0] BtnWheelDown = 3'd5;
  localparam logic [2:0] BtnBad7      = 3'd7;

  localparam logic [2:0] ModShift = 3'b001;
  localparam logic [2:0] ModAlt   = 3'b010;
  localparam logic [2:0] ModCtrl  = 3'b100;
  localparam logic [2:0] ModAll   = 3'b111;

  localparam int DragOffset = 32;
  localparam int MoveCode   = 35;
  localparam int WheelBase  = 64;
  localparam int ShiftAdd   = 4;
  localparam int AltAdd     = 8;
  localparam int CtrlAdd    = 16;

  localparam int SettleCycles  = 30;
  localparam int CycleLimit    = 400000;
  localparam int RandomItems   = 155;
  localparam int PhaseItems    = 20;
  localparam int HoldAtBeat    = 400;
  localparam int HoldCycles    = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } report_beat_t;

  // len < 0: use predictor, len >= 0: typed report text
  typedef struct packed {
    logic         sgr;
    logic [2:0]   mode;
    logic [2:0]   kind;
    logic [2:0]   btn;
    logic [2:0]   mods;
    logic [15:0]  row;
    logic [15:0]  col;
    int           len;
    logic [143:0] text;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  event_kind_i = '0;
  logic [2:0]  button_i     = '0;
  logic [2:0]  modifiers_i  = '0;
  logic [15:0] row_i        = '0;
  logic [15:0] column_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i  = 1'b0;
  logic [2:0]  cfg_data_i   = '0;

  report_beat_t report_q[$];
  logic         sgr_en   = 1'b0;
  logic [2:0]   trk_mode = TrkNone;
  int           fail_cnt = 0;
  int           item_idx = 0;
  int           out_beats = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  dir_row_t dir_tab [0:24] = '{
    '{1'b0, TrkNone,     KindPress,   BtnLeft,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkNone,     KindPress,   BtnLeft,      3'd0,   16'd5, 16'd5, 0, 0},
    '{1'b1, TrkX10,      KindPress,   BtnMiddle,    3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b0, TrkAny,      KindPress,   BtnLeft,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkPressRel, KindPress,   BtnLeft,      3'd0,   16'd0, 16'd0, 9,
      "\033[<0;1;1M"},
    '{1'b1, TrkPressRel, KindRelease, BtnRight,     ModAll, 16'h7fff, 16'h7fff, 18,
      "\033[<30;32768;32768m"},
    '{1'b1, TrkPressRel, KindPress,   BtnMiddle,    ModShift, 16'd41, 16'd7, -1, 0},
    '{1'b1, TrkPressRel, KindPress,   BtnNone,      3'd0,   16'd1, 16'd1, 0, 0},
    '{1'b1, TrkPressRel, KindRelease, BtnBad7,      3'd0,   16'd1, 16'd1, 0, 0},
    '{1'b1, TrkPressRel, KindPress,   BtnLeft,      3'd0,   16'hffff, 16'd3, 0, 0},
    '{1'b1, TrkPressRel, KindPress,   BtnLeft,      3'd0,   16'd2, 16'h8000, 0, 0},
    '{1'b1, TrkPressRel, KindDrag,    BtnLeft,      3'd0,   16'd2, 16'd2, 0, 0},
    '{1'b1, TrkPressRel, KindMove,    BtnNone,      3'd0,   16'd2, 16'd2, 0, 0},
    '{1'b1, TrkPressRel, KindWheel,   BtnWheelUp,   ModAlt, 16'd123, 16'd4567, -1, 0},
    '{1'b1, TrkPressRel, KindWheel,   BtnWheelDown, ModCtrl, 16'd0, 16'd0, 10,
      "\033[<81;1;1M"},
    '{1'b1, TrkPressRel, KindWheel,   BtnLeft,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkPressRel, KindUnk5,    BtnLeft,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkPressRel, KindUnk7,    BtnLeft,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkButton,   KindDrag,    BtnMiddle,    ModShift | ModAlt, 16'd99, 16'd999,
      -1, 0},
    '{1'b1, TrkButton,   KindDrag,    BtnNone,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkButton,   KindMove,    BtnNone,      3'd0,   16'd0, 16'd0, 0, 0},
    '{1'b1, TrkAny,      KindMove,    BtnBad7,      ModAll, 16'd9999, 16'd10000, -1, 0},
    '{1'b1, TrkAny,      KindDrag,    BtnRight,     3'd0,   16'd0, 16'd9, -1, 0},
    '{1'b1, TrkUnk7,     KindPress,   BtnRight,     ModCtrl, 16'd8, 16'd98, -1, 0},
    '{1'b1, TrkUnk7,     KindDrag,    BtnLeft,      3'd0,   16'd8, 16'd98, 0, 0}
  };

  sgr_mouse_report_encoder_top DUT (.*);

  always #10 clk_i = ~clk_i;

  function automatic void push_beat(input logic [7:0] b, input logic l);
    report_q.push_back('{data: b, last: l});
  endfunction

  function automatic void push_decimal(input int v);
    int div;
    int d;
    bit started;
    div = 10000;
    started = 1'b0;
    while (div > 0) begin
      d = (v / div) % 10;
      if (d != 0 || started || div == 1) begin
        push_beat(ByteZero + 8'(d), 1'b0);
        started = 1'b1;
      end
      div = div / 10;
    end
  endfunction

  // queues the report bytes of one event, returns how many
  function automatic int predict_report(input logic [2:0] kind, input logic [2:0] btn,
                                        input logic [2:0] mods, input logic [15:0] row,
                                        input logic [15:0] col);
    int code;
    int n0;
    logic [7:0] fin;
    n0 = report_q.size();
    fin = BytePress;
    code = 0;
    if (!sgr_en || trk_mode <= TrkX10 || row[15] || col[15]) return 0;
    case (kind)
      KindPress: begin
        if (btn > BtnRight) return 0;
        code = int'(btn);
      end
      KindRelease: begin
        if (btn > BtnRight) return 0;
        code = int'(btn);
        fin = ByteRel;
      end
      KindDrag: begin
        if (trk_mode != TrkButton && trk_mode != TrkAny) return 0;
        if (btn > BtnRight) return 0;
        code = int'(btn) + DragOffset;
      end
      KindMove: begin
        if (trk_mode != TrkAny) return 0;
        code = MoveCode;
      end
      KindWheel: begin
        if (btn != BtnWheelUp && btn != BtnWheelDown) return 0;
        code = WheelBase + int'(btn - BtnWheelUp);
      end
      default: return 0;
    endcase
    if (mods & ModShift) code += ShiftAdd;
    if (mods & ModAlt) code += AltAdd;
    if (mods & ModCtrl) code += CtrlAdd;
    push_beat(ByteEsc, 1'b0);
    push_beat(ByteLbr, 1'b0);
    push_beat(ByteLt, 1'b0);
    push_decimal(code);
    push_beat(ByteSemi, 1'b0);
    push_decimal(int'(col) + 1);
    push_beat(ByteSemi, 1'b0);
    push_decimal(int'(row) + 1);
    push_beat(fin, 1'b1);
    return report_q.size() - n0;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 8));
      1:       return 16'($urandom_range(9, 98));
      2:       return 16'($urandom_range(99, 998));
      3:       return 16'($urandom_range(999, 9998));
      default: return 16'($urandom_range(9999, 32767));
    endcase
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [2:0] sgr_data, input logic [2:0] mode);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegSgr;
    cfg_data_i  <= sgr_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sgr_en = sgr_data[0];
    cfg_index_i <= RegTrk;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    trk_mode = mode;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_event(input logic [2:0] kind, input logic [2:0] btn,
                            input logic [2:0] mods, input logic [15:0] row,
                            input logic [15:0] col, input int len,
                            input logic [143:0] text);
    // no sender gaps for a stretch of the random part
    if (item_idx < 100 || item_idx >= 140) begin
      while ($urandom_range(0, 99) < 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    event_kind_i <= kind;
    button_i     <= btn;
    modifiers_i  <= mods;
    row_i        <= row;
    column_i     <= col;
    do @(posedge clk_i); while (in_stall_o);
    if (len < 0) begin
      void'(predict_report(kind, btn, mods, row, col));
    end else begin
      for (int i = 0; i < len; i++) push_beat(text[(len - 1 - i) * 8 +: 8], i == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    report_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_beats++;
      if (report_q.size() == 0) begin
        $error("out_byte: no beat expected, got %h (last %b)", out_byte_o, last_o);
        fail_cnt++;
      end else begin
        exp_beat = report_q.pop_front();
        if (out_byte_o !== exp_beat.data) begin
          $error("out_byte: expected %h, got %h", exp_beat.data, out_byte_o);
          fail_cnt++;
        end
        if (last_o !== exp_beat.last) begin
          $error("last: expected %b, got %b", exp_beat.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!hold_done && out_beats >= HoldAtBeat) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_beats >= 800 && out_beats < 1200) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 6);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase;
    int n_ok;
    logic [2:0] mode;
    logic [2:0] kind;
    logic [2:0] btn;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0] phase_mode [0:7];
    phase_mode = '{TrkAny, TrkButton, TrkPressRel, TrkUnk5,
                   TrkAny, TrkAny, TrkUnk6, TrkButton};
    phase = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].sgr != sgr_en || dir_tab[i].mode != trk_mode)
        apply_config({2'($urandom_range(0, 3)), dir_tab[i].sgr}, dir_tab[i].mode);
      send_event(dir_tab[i].kind, dir_tab[i].btn, dir_tab[i].mods, dir_tab[i].row,
                 dir_tab[i].col, dir_tab[i].len, dir_tab[i].text);
    end

    while (item_idx < RandomItems) begin
      mode = phase_mode[phase % 8];
      // one phase with SGR off
      apply_config({2'($urandom_range(0, 3)), 1'(phase != 5)}, mode);
      for (int i = 0; i < PhaseItems && item_idx < RandomItems; i++) begin
        if ($urandom_range(0, 99) < 80) begin
          n_ok = (mode == TrkAny) ? 5 : (mode == TrkButton) ? 4 : 3;
          case ($urandom_range(0, n_ok - 1))
            0: begin kind = KindPress;   btn = 3'($urandom_range(0, 2)); end
            1: begin kind = KindRelease; btn = 3'($urandom_range(0, 2)); end
            2: begin kind = KindWheel;   btn = 3'($urandom_range(4, 5)); end
            3: begin kind = KindDrag;    btn = 3'($urandom_range(0, 2)); end
            default: begin kind = KindMove; btn = 3'($urandom_range(0, 7)); end
          endcase
          row = pick_coord();
          col = pick_coord();
        end else begin
          kind = 3'($urandom_range(0, 7));
          btn  = 3'($urandom_range(0, 7));
          row  = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(32768, 65535))
                                             : pick_coord();
          col  = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(32768, 65535))
                                             : pick_coord();
        end
        send_event(kind, btn, 3'($urandom_range(0, 7)), row, col, -1, 0);
        item_idx++;
      end
      phase++;
    end

    settle();
    if (fail_cnt == 0 && report_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
